// ----- src/pss_pkg.sv -----
// pss_pkg: field widths, operation codes and status codes for the
// positional sequence store; no dependencies
`timescale 1ns / 1ps

package pss_pkg;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 6;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t OP_INSERT = 2'd0;
  localparam func_t OP_DELETE = 2'd1;
  localparam func_t OP_READ   = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- src/pss_if.sv -----
// pss_if: valid/ready channel interfaces for request and result beats
// depends on pss_pkg for field widths
`timescale 1ns / 1ps

interface pss_req_if;
  import pss_pkg::*;

  logic                     valid;
  logic                     ready;
  func_t                    func;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface pss_rsp_if;
  import pss_pkg::*;

  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] data;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output status, output data, output length, input ready);
  modport sink   (input valid, input status, input data, input length, output ready);
endinterface

// ----- src/positional_sequence_store.sv -----
// positional_sequence_store: bounded ordered list with insert, delete and
// read by position; depends on pss_pkg and the channel interfaces in pss_if
`timescale 1ns / 1ps

//  channel | dir | fields                     | beat taken when
//  --------+-----+----------------------------+---------------------
//  req     | in  | func, position, value      | req.valid & req.ready
//  rsp     | out | status, data, length       | rsp.valid & rsp.ready
//
// one request a cycle sustained while rsp takes results; the request register loads at the request beat,
// the result register loads from it when the request advances, and the result beat follows from the result register
// every entry holds, shifts up, shifts down or loads in the same cycle
// reset clears the length and the valid flags only; entries are never cleared, there is no sweep
// a stall on rsp backs up through the result and request registers

module positional_sequence_store #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  pss_req_if.sink   req,
  pss_rsp_if.source rsp
);
  import pss_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // request register
  logic              s1_valid;
  func_t             s1_func;
  logic [POS_W-1:0]  s1_pos;
  logic [DATA_W-1:0] s1_value;

  // result register
  logic              r_valid;
  status_t           r_status;
  logic [DATA_W-1:0] r_data;
  logic [LEN_W-1:0]  r_length;

  // list state
  logic [DATA_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic              advance;
  logic              take_req;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  count_x;
  logic [CMP_W-1:0]  count_next_x;
  logic [IDX_W-1:0]  pos_idx;
  logic              full;
  status_t           status_next;
  logic [DATA_W-1:0] data_next;
  logic              do_insert;
  logic              do_delete;

  assign advance  = s1_valid && (!r_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign take_req = req.valid && req.ready;

  assign pos_x   = CMP_W'(s1_pos);
  assign count_x = CMP_W'(count);
  assign pos_idx = pos_x[IDX_W-1:0];
  assign full    = (count == CNT_W'(CAPACITY));

  always_comb begin
    status_next = ST_RANGE;
    data_next   = '0;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    count_next  = count;
    case (s1_func)
      OP_INSERT: begin
        // a bad position is reported before a full store
        if (pos_x > count_x) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          do_insert   = 1'b1;
          count_next  = count + 1'b1;
        end
      end
      OP_DELETE, OP_READ: begin
        if (pos_x < count_x) begin
          status_next = ST_DONE;
          data_next   = entries[pos_idx];
          if (s1_func == OP_DELETE) begin
            do_delete  = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign count_next_x = CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      r_valid  <= 1'b0;
      count    <= '0;
    end else begin
      if (take_req) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        r_valid <= 1'b1;
        count   <= count_next;
      end else if (rsp.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_req) begin
      s1_func  <= req.func;
      s1_pos   <= req.position;
      s1_value <= req.value;
    end
    if (advance) begin
      r_status <= status_next;
      r_data   <= data_next;
      r_length <= count_next_x[LEN_W-1:0];
    end
  end

  // each entry picks its own neighbour by comparing its index with the position
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (do_insert) begin
          if (CMP_W'(k) == pos_x) begin
            entries[k] <= s1_value;
          end else if (k > 0 && CMP_W'(k) > pos_x) begin
            entries[k] <= entries[(k > 0) ? k - 1 : 0];
          end
        end else if (do_delete) begin
          if (k < CAPACITY - 1 && CMP_W'(k) >= pos_x) begin
            entries[k] <= entries[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end
    end
  end

  assign rsp.valid  = r_valid;
  assign rsp.status = r_status;
  assign rsp.data   = r_data;
  assign rsp.length = r_length;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(CAPACITY) >= count)
    else $error("length beyond capacity");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    advance && status_next == ST_FULL |-> count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_length_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid && rsp.length == count_x[LEN_W-1:0])
    else $error("result length differs from held count");

  a_error_data_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_DONE |-> rsp.data == '0)
    else $error("rejected request returned data");

endmodule
